FILE: design/console_key_escape_decoder_defines.svh
// ----------------------------------------------------------------------------
// console key escape decoder assertion macros
// shared helpers for concurrent checks on the rising edge of clk
// ----------------------------------------------------------------------------
`ifndef CONSOLE_KEY_ESCAPE_DECODER_DEFINES_SVH
`define CONSOLE_KEY_ESCAPE_DECODER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CKD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define CKD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ckd_pkg.sv
// ----------------------------------------------------------------------------
// ckd_pkg
// types, codes and byte constants of the console key escape decoder
// ----------------------------------------------------------------------------
package ckd_pkg;

  // register file layout
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTN   = 1'd1;

  // register reset values
  localparam logic [7:0] TOGGLE_RST = 8'd5;
  localparam logic [7:0] ATTN_RST   = 8'd0;

  // result kinds
  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_RAW  = 2'd1;
  localparam logic [1:0] KIND_MODE = 2'd2;
  localparam logic [1:0] KIND_ATTN = 2'd3;

  // edit key codes
  localparam logic [3:0] K_ASCII    = 4'd0;
  localparam logic [3:0] K_BOL      = 4'd1;
  localparam logic [3:0] K_LEFT     = 4'd2;
  localparam logic [3:0] K_CANCEL   = 4'd3;
  localparam logic [3:0] K_DEL      = 4'd4;
  localparam logic [3:0] K_EOL      = 4'd5;
  localparam logic [3:0] K_RIGHT    = 4'd6;
  localparam logic [3:0] K_BS       = 4'd7;
  localparam logic [3:0] K_COMPLETE = 4'd8;
  localparam logic [3:0] K_ACCEPT   = 4'd9;
  localparam logic [3:0] K_KILL     = 4'd10;
  localparam logic [3:0] K_DOWN     = 4'd11;
  localparam logic [3:0] K_UP       = 4'd12;
  localparam logic [3:0] K_SUP      = 4'd13;
  localparam logic [3:0] K_SDOWN    = 4'd14;
  localparam logic [3:0] K_POS      = 4'd15;

  // special bytes
  localparam logic [7:0] CH_CTRL_A = 8'h01;
  localparam logic [7:0] CH_CTRL_B = 8'h02;
  localparam logic [7:0] CH_CTRL_C = 8'h03;
  localparam logic [7:0] CH_CTRL_D = 8'h04;
  localparam logic [7:0] CH_CTRL_E = 8'h05;
  localparam logic [7:0] CH_CTRL_F = 8'h06;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CTRL_K = 8'h0B;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_CTRL_N = 8'h0E;
  localparam logic [7:0] CH_CTRL_P = 8'h10;
  localparam logic [7:0] CH_CTRL_R = 8'h12;
  localparam logic [7:0] CH_CTRL_S = 8'h13;
  localparam logic [7:0] CH_CTRL_V = 8'h16;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UP_R   = 8'h52;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_B   = 8'h42;
  localparam logic [7:0] CH_UP_C   = 8'h43;
  localparam logic [7:0] CH_UP_D   = 8'h44;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // escape decode states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_QUOTE = 3'd1,
    ST_ESC   = 3'd2,
    ST_BRAK  = 3'd3,
    ST_ROW   = 3'd4,
    ST_COL   = 3'd5
  } dec_state_t;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  key_code;
    logic [7:0]  char_out;
    logic [15:0] pos_row;
    logic [15:0] pos_col;
    logic        mode_now;
  } result_t;

  // decode stage output toward the result register
  typedef struct packed {
    logic    valid;
    result_t res;
  } dec_out_t;

endpackage

FILE: design/ckd_if.sv
// ----------------------------------------------------------------------------
// ckd channel interfaces
// valid/ready channels for received bytes and for decoded results
// ----------------------------------------------------------------------------
interface ckd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface ckd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  key_code;
  logic [7:0]  char_out;
  logic [15:0] pos_row;
  logic [15:0] pos_col;
  logic        mode_now;

  modport source (output valid, output kind, output key_code, output char_out,
                  output pos_row, output pos_col, output mode_now, input ready);
  modport sink   (input valid, input kind, input key_code, input char_out,
                  input pos_row, input pos_col, input mode_now, output ready);
endinterface

FILE: design/console_key_escape_decoder.sv
// ----------------------------------------------------------------------------
// console_key_escape_decoder
// terminal byte decoder: mode toggle, attention, raw pass-through, control
// keys, quoting and ESC [ arrow and cursor position report decoding
// ----------------------------------------------------------------------------
// Takes one byte per clock and gives at most one result word per byte, in
// order. A byte goes into an input register, is decoded against the decode
// state, and its result lands in the output register. The decode state is
// updated as the byte leaves the input register, so bytes stream at one per
// cycle while the output side takes words; a stalled output holds the
// pipeline and, once the input register is full, drops in_ch.ready. Bytes
// that give no result (ESC, digits of a report, Ctrl-V and so on) still pass
// the decode stage and move the decode state like any byte. Registers are
// written through cfg_we/cfg_index/cfg_data and should only change while no
// byte is in flight.
// ----------------------------------------------------------------------------
`include "console_key_escape_decoder_defines.svh"

module console_key_escape_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ckd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ckd_pkg::CFG_DATA_W-1:0]   cfg_data,
  ckd_in_if.sink                           in_ch,
  ckd_out_if.source                        out_ch
);
  import ckd_pkg::*;

  logic [7:0] toggle_byte_r;
  logic [7:0] attn_byte_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_r;
  logic       out_free;
  logic       advance;
  logic       in_fire;
  dec_out_t   dec_out;

  // handshake and stage advance
  assign out_free     = !out_valid_r || out_ch.ready;
  assign advance      = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toggle_byte_r <= TOGGLE_RST;
      attn_byte_r   <= ATTN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOGGLE: toggle_byte_r <= cfg_data;
        CFG_ATTN:   attn_byte_r   <= cfg_data;
        default:    toggle_byte_r <= toggle_byte_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.in_byte;
    end
  end

  // decode stage
  ckd_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .byte_in        (s1_byte_r),
    .toggle_byte    (toggle_byte_r),
    .attention_byte (attn_byte_r),
    .dec_out        (dec_out)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && dec_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec_out.valid) begin
      out_r <= dec_out.res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_r.kind;
  assign out_ch.key_code = out_r.key_code;
  assign out_ch.char_out = out_r.char_out;
  assign out_ch.pos_row  = out_r.pos_row;
  assign out_ch.pos_col  = out_r.pos_col;
  assign out_ch.mode_now = out_r.mode_now;

  // checks
  `CKD_ASSERT_NEXT(a_result_lands, advance && dec_out.valid, out_valid_r, "decoded result lost before result register")
  `CKD_ASSERT_SAME(a_nonkey_clean, out_valid_r && (out_r.kind != KIND_KEY), (out_r.key_code == K_ASCII) && (out_r.pos_row == 16'd0) && (out_r.pos_col == 16'd0), "non-key result carries key fields")
  `CKD_ASSERT_SAME(a_pos_only_report, out_valid_r && (out_r.key_code != K_POS), (out_r.pos_row == 16'd0) && (out_r.pos_col == 16'd0), "position fields set outside a report")

endmodule

FILE: design/ckd_decode.sv
// ----------------------------------------------------------------------------
// ckd_decode
// decode state machine: holds mode, escape state and number accumulators,
// and turns one byte per advance into at most one result word
// ----------------------------------------------------------------------------
module ckd_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic [7:0]      byte_in,
  input  logic [7:0]      toggle_byte,
  input  logic [7:0]      attention_byte,
  output ckd_pkg::dec_out_t dec_out
);
  import ckd_pkg::*;

  dec_state_t  state_r, state_nxt;
  logic        mode_r, mode_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] col_r, col_nxt;

  logic        is_digit;
  logic [3:0]  digit;
  logic        hit_toggle;
  logic        hit_attn;

  // acc * 10 + d, clamped to 16 bits
  function automatic logic [15:0] sat_acc(input logic [15:0] acc, input logic [3:0] d);
    logic [19:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {16'd0, d};
    return (v > 20'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  // control key lookup for command mode, idle state
  function automatic logic [3:0] ctrl_key(input logic [7:0] c);
    logic [3:0] k;
    unique case (c)
      CH_CTRL_A:        k = K_BOL;
      CH_CTRL_B:        k = K_LEFT;
      CH_CTRL_C:        k = K_CANCEL;
      CH_CTRL_D:        k = K_DEL;
      CH_CTRL_E:        k = K_EOL;
      CH_CTRL_F:        k = K_RIGHT;
      CH_BS, CH_DEL:    k = K_BS;
      CH_TAB:           k = K_COMPLETE;
      CH_LF, CH_CR:     k = K_ACCEPT;
      CH_CTRL_K:        k = K_KILL;
      CH_CTRL_N:        k = K_DOWN;
      CH_CTRL_P:        k = K_UP;
      CH_CTRL_S:        k = K_SUP;
      CH_CTRL_R:        k = K_SDOWN;
      default:          k = K_ASCII;
    endcase
    return k;
  endfunction

  // byte classification
  always_comb begin
    is_digit   = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    digit      = byte_in[3:0];
    hit_toggle = (byte_in == toggle_byte);
    hit_attn   = (attention_byte != 8'd0) && (byte_in == attention_byte);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    priority if (state_r == ST_QUOTE) begin
      state_nxt = ST_IDLE;
    end else if (hit_toggle) begin
      mode_nxt = ~mode_r;
    end else if (hit_attn) begin
      state_nxt = state_r;
    end else if (mode_r) begin
      unique case (state_r)
        ST_ESC: begin
          state_nxt = (byte_in == CH_LBRACK) ? ST_BRAK : ST_IDLE;
        end
        ST_BRAK: begin
          state_nxt = ST_IDLE;
          if (is_digit) begin
            row_nxt   = {12'd0, digit};
            state_nxt = ST_ROW;
          end
        end
        ST_ROW: begin
          priority if (is_digit) begin
            row_nxt = sat_acc(row_r, digit);
          end else if (byte_in == CH_SEMI) begin
            col_nxt   = 16'd0;
            state_nxt = ST_COL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
        ST_COL: begin
          if (is_digit) begin
            col_nxt = sat_acc(col_r, digit);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
        default: begin
          // idle, and any code that should not occur
          priority if (byte_in == CH_CTRL_V) begin
            state_nxt = ST_QUOTE;
          end else if (byte_in == CH_ESC) begin
            state_nxt = ST_ESC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      endcase
    end
  end

  // result word
  always_comb begin
    dec_out              = '0;
    dec_out.res.mode_now = mode_nxt;
    priority if (state_r == ST_QUOTE) begin
      dec_out.valid        = 1'b1;
      dec_out.res.kind     = KIND_KEY;
      dec_out.res.key_code = K_ASCII;
      dec_out.res.char_out = byte_in;
    end else if (hit_toggle) begin
      dec_out.valid    = 1'b1;
      dec_out.res.kind = KIND_MODE;
    end else if (hit_attn) begin
      dec_out.valid    = 1'b1;
      dec_out.res.kind = KIND_ATTN;
    end else if (!mode_r) begin
      dec_out.valid        = 1'b1;
      dec_out.res.kind     = KIND_RAW;
      dec_out.res.char_out = byte_in;
    end else begin
      dec_out.res.kind = KIND_KEY;
      unique case (state_r)
        ST_ESC, ST_ROW: begin
          dec_out.valid = 1'b0;
        end
        ST_BRAK: begin
          dec_out.valid = (byte_in == CH_UP_A) || (byte_in == CH_UP_B) ||
                          (byte_in == CH_UP_C) || (byte_in == CH_UP_D);
          priority if (byte_in == CH_UP_A) begin
            dec_out.res.key_code = K_UP;
          end else if (byte_in == CH_UP_B) begin
            dec_out.res.key_code = K_DOWN;
          end else if (byte_in == CH_UP_C) begin
            dec_out.res.key_code = K_RIGHT;
          end else begin
            dec_out.res.key_code = K_LEFT;
          end
        end
        ST_COL: begin
          // cursor report ends on R
          dec_out.valid        = (byte_in == CH_UP_R);
          dec_out.res.key_code = K_POS;
          dec_out.res.pos_row  = row_r;
          dec_out.res.pos_col  = col_r;
        end
        default: begin
          dec_out.valid        = (byte_in != CH_CTRL_V) && (byte_in != CH_ESC);
          dec_out.res.key_code = ctrl_key(byte_in);
          dec_out.res.char_out = byte_in;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= 1'b0;
      row_r   <= 16'd0;
      col_r   <= 16'd0;
    end else if (advance) begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

FILE: sim/console_key_escape_decoder_tb.sv
// ----------------------------------------------------------------------------
// console_key_escape_decoder_tb
// drives terminal bytes into the decoder and checks every result word against
// a cycle-free model of the decoder held in the bench. A short table of
// directed bytes comes first, then phases of random key sequences under different
// toggle and attention settings, with random gaps on both channels outside the
// steady phases, one long output stall and a full drain before each new setting.
// ----------------------------------------------------------------------------
module console_key_escape_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ckd_pkg::*;

  localparam int unsigned RAND_ITEMS = 1650;
  localparam int unsigned N_PHASES   = 8;
  localparam int unsigned DRAIN_CYC  = 8;
  localparam int unsigned HOLD_CYC   = 400;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum logic [0:0] {
    ROW_BYTE = 1'b0,
    ROW_CFG  = 1'b1
  } row_op_t;

  // one row of the directed table
  typedef struct packed {
    row_op_t                 op;
    logic [7:0]              val;
    logic [CFG_IDX_W-1:0]    idx;
    logic                    typed;
    result_t                 res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ckd_in_if  in_ch ();
  ckd_out_if out_ch ();

  console_key_escape_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #1 clk = ~clk;

  // bench copy of decoder state and registers
  dec_state_t  key_st   = ST_IDLE;
  logic        cmd_on   = 1'b0;
  logic [15:0] rep_row  = '0;
  logic [15:0] rep_col  = '0;
  logic [7:0]  tog_byte = TOGGLE_RST;
  logic [7:0]  att_byte = ATTN_RST;

  result_t expected_words [$];

  // side info sent along with each byte for table rows
  logic    tab_typed;
  result_t tab_res;

  logic        steady  = 1'b0;
  logic        rx_hold = 1'b0;
  logic        gen_cmd = 1'b0;
  event        hold_ev;

  int unsigned cycle_cnt = 0;
  int unsigned err_cnt   = 0;
  int unsigned word_cnt  = 0;
  int unsigned byte_cnt  = 0;
  int unsigned rand_cnt  = 0;
  int unsigned cfg_cnt   = 0;
  int unsigned key_cnt   = 0;
  int unsigned pos_cnt   = 0;
  int unsigned raw_cnt   = 0;
  int unsigned mode_cnt  = 0;
  int unsigned attn_cnt  = 0;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // idle cycles before the next word on either side
  function automatic int unsigned draw_wait();
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  // one more decimal digit, clamped at the 16-bit top
  function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] c);
    int unsigned v;
    v = acc * 10 + (c - CH_ZERO);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // advance the bench decoder by one byte; returns 1 when a word is due
  function automatic logic decode_key_byte(input logic [7:0] c, output result_t r);
    logic digit;
    r = '0;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    // a pending quote wins over everything
    if (key_st == ST_QUOTE) begin
      key_st = ST_IDLE;
      r.kind = KIND_KEY;
      r.key_code = K_ASCII;
      r.char_out = c;
      r.mode_now = cmd_on;
      return 1'b1;
    end
    if (c == tog_byte) begin
      cmd_on = ~cmd_on;
      r.kind = KIND_MODE;
      r.mode_now = cmd_on;
      return 1'b1;
    end
    if (att_byte != 8'd0 && c == att_byte) begin
      r.kind = KIND_ATTN;
      r.mode_now = cmd_on;
      return 1'b1;
    end
    if (!cmd_on) begin
      r.kind = KIND_RAW;
      r.char_out = c;
      return 1'b1;
    end
    r.kind = KIND_KEY;
    r.mode_now = 1'b1;
    case (key_st)
      ST_ESC: begin
        key_st = (c == CH_LBRACK) ? ST_BRAK : ST_IDLE;
        return 1'b0;
      end
      ST_BRAK: begin
        key_st = ST_IDLE;
        case (c)
          CH_UP_A: r.key_code = K_UP;
          CH_UP_B: r.key_code = K_DOWN;
          CH_UP_C: r.key_code = K_RIGHT;
          CH_UP_D: r.key_code = K_LEFT;
          default: begin
            if (digit) begin
              rep_row = {8'd0, c - CH_ZERO};
              key_st = ST_ROW;
            end
            return 1'b0;
          end
        endcase
        return 1'b1;
      end
      ST_ROW: begin
        if (digit) begin
          rep_row = add_digit(rep_row, c);
        end else if (c == CH_SEMI) begin
          rep_col = '0;
          key_st = ST_COL;
        end else begin
          key_st = ST_IDLE;
        end
        return 1'b0;
      end
      ST_COL: begin
        if (digit) begin
          rep_col = add_digit(rep_col, c);
          return 1'b0;
        end
        key_st = ST_IDLE;
        if (c != CH_UP_R) return 1'b0;
        r.key_code = K_POS;
        r.pos_row = rep_row;
        r.pos_col = rep_col;
        return 1'b1;
      end
      default: begin
        key_st = ST_IDLE;
        r.char_out = c;
        case (c)
          CH_CTRL_A:      r.key_code = K_BOL;
          CH_CTRL_B:      r.key_code = K_LEFT;
          CH_CTRL_C:      r.key_code = K_CANCEL;
          CH_CTRL_D:      r.key_code = K_DEL;
          CH_CTRL_E:      r.key_code = K_EOL;
          CH_CTRL_F:      r.key_code = K_RIGHT;
          CH_BS, CH_DEL:  r.key_code = K_BS;
          CH_TAB:         r.key_code = K_COMPLETE;
          CH_LF, CH_CR:   r.key_code = K_ACCEPT;
          CH_CTRL_K:      r.key_code = K_KILL;
          CH_CTRL_N:      r.key_code = K_DOWN;
          CH_CTRL_P:      r.key_code = K_UP;
          CH_CTRL_S:      r.key_code = K_SUP;
          CH_CTRL_R:      r.key_code = K_SDOWN;
          CH_CTRL_V: begin
            key_st = ST_QUOTE;
            return 1'b0;
          end
          CH_ESC: begin
            key_st = ST_ESC;
            return 1'b0;
          end
          default:        r.key_code = K_ASCII;
        endcase
        return 1'b1;
      end
    endcase
  endfunction

  // one line per mismatch, printing capped
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    err_cnt++;
    if (err_cnt <= 40)
      $display("%0t ns word %0d: %s got %0h want %0h", $realtime, word_cnt, what, got, want);
  endtask

  // compare the word on the output channel with the oldest expectation
  task automatic check_word();
    result_t want;
    word_cnt++;
    if (expected_words.size() == 0) begin
      report_mismatch("word with nothing expected, kind", 16'(out_ch.kind), 16'd0);
      return;
    end
    want = expected_words.pop_front();
    case (want.kind)
      KIND_KEY:  if (want.key_code == K_POS) pos_cnt++; else key_cnt++;
      KIND_RAW:  raw_cnt++;
      KIND_MODE: mode_cnt++;
      default:   attn_cnt++;
    endcase
    if (out_ch.kind !== want.kind)
      report_mismatch("kind", 16'(out_ch.kind), 16'(want.kind));
    if (out_ch.key_code !== want.key_code)
      report_mismatch("key_code", 16'(out_ch.key_code), 16'(want.key_code));
    if (out_ch.char_out !== want.char_out)
      report_mismatch("char_out", 16'(out_ch.char_out), 16'(want.char_out));
    if (out_ch.pos_row !== want.pos_row)
      report_mismatch("pos_row", out_ch.pos_row, want.pos_row);
    if (out_ch.pos_col !== want.pos_col)
      report_mismatch("pos_col", out_ch.pos_col, want.pos_col);
    if (out_ch.mode_now !== want.mode_now)
      report_mismatch("mode_now", 16'(out_ch.mode_now), 16'(want.mode_now));
  endtask

  // monitor: check outgoing words, then predict for the byte taken
  always @(posedge clk) begin : monitor
    result_t pred;
    logic    due;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_word();
      if (in_ch.valid && in_ch.ready) begin
        due = decode_key_byte(in_ch.in_byte, pred);
        if (tab_typed) expected_words.push_back(tab_res);
        else if (due) expected_words.push_back(pred);
      end
    end
  end

  // receiver: random stall before each word, plus the long hold-off
  initial begin : receiver
    int unsigned stall;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait();
      if (stall != 0 || rx_hold) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // long output hold-off, counted here
  initial begin : hold_off
    forever begin
      @(hold_ev);
      rx_hold <= 1'b1;
      repeat (HOLD_CYC) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d words pending", cycle_cnt, expected_words.size());
    $display("[console_key_escape_decoder] ERROR");
    $finish;
  end

  // offer one byte after a random gap and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic typed, input result_t res);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    tab_typed     <= typed;
    tab_res       <= res;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    byte_cnt++;
  endtask

  // stop sending and let every pending word and no-result byte clear
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // register write, only while the decoder is idle
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TOGGLE) tog_byte = val;
    else att_byte = val;
    cfg_cnt++;
    @(posedge clk);
  endtask

  function automatic row_t mk_row(input row_op_t op, input logic [7:0] val,
                                  input logic [CFG_IDX_W-1:0] idx, input logic typed,
                                  input result_t res);
    row_t r;
    r.op = op;
    r.val = val;
    r.idx = idx;
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  function automatic row_t byte_row(input logic [7:0] val);
    return mk_row(ROW_BYTE, val, CFG_TOGGLE, 1'b0, '0);
  endfunction

  // one random token: well-formed key sequence, toggle or attention byte, noise or a broken sequence
  task automatic send_token();
    logic [7:0] tq [$];
    logic [7:0] d;
    int unsigned r, n;
    r = $urandom_range(0, 99);
    if (!gen_cmd && r < 40) begin
      tq.push_back(tog_byte);
      gen_cmd = 1'b1;
    end else if (r < 14) begin
      // arrow key
      tq.push_back(CH_ESC);
      tq.push_back(CH_LBRACK);
      d = 8'(CH_UP_A + $urandom_range(0, 3));
      tq.push_back(d);
    end else if (r < 28) begin
      // cursor position report, now and then with long numbers
      tq.push_back(CH_ESC);
      tq.push_back(CH_LBRACK);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
      repeat (n) begin
        d = 8'(CH_ZERO + $urandom_range(0, 9));
        tq.push_back(d);
      end
      tq.push_back(CH_SEMI);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 3);
      repeat (n) begin
        d = 8'(CH_ZERO + $urandom_range(0, 9));
        tq.push_back(d);
      end
      tq.push_back(CH_UP_R);
    end else if (r < 42) begin
      // control keys
      case ($urandom_range(0, 14))
        0:       d = CH_CTRL_A;
        1:       d = CH_CTRL_B;
        2:       d = CH_CTRL_C;
        3:       d = CH_CTRL_D;
        4:       d = CH_CTRL_E;
        5:       d = CH_CTRL_F;
        6:       d = CH_BS;
        7:       d = CH_TAB;
        8:       d = CH_LF;
        9:       d = CH_CTRL_K;
        10:      d = CH_CR;
        11:      d = CH_CTRL_N;
        12:      d = CH_CTRL_P;
        13:      d = CH_CTRL_R;
        default: d = ($urandom_range(0, 1) != 0) ? CH_CTRL_S : CH_DEL;
      endcase
      tq.push_back(d);
    end else if (r < 50) begin
      // quoted byte
      tq.push_back(CH_CTRL_V);
      d = 8'($urandom_range(0, 255));
      tq.push_back(d);
    end else if (r < 66) begin
      d = 8'($urandom_range(8'h20, 8'h7E));
      tq.push_back(d);
    end else if (r < 78) begin
      // sequence cut short by a stray byte
      tq.push_back(CH_ESC);
      if ($urandom_range(0, 2) != 0) begin
        tq.push_back(CH_LBRACK);
        if ($urandom_range(0, 1) != 0) begin
          d = 8'(CH_ZERO + $urandom_range(0, 9));
          tq.push_back(d);
          if ($urandom_range(0, 1) != 0) tq.push_back(CH_SEMI);
        end
      end
      d = 8'($urandom_range(0, 255));
      tq.push_back(d);
    end else if (r < 83) begin
      tq.push_back(tog_byte);
      gen_cmd = ~gen_cmd;
    end else if (r < 88) begin
      tq.push_back(att_byte);
    end else begin
      d = 8'($urandom_range(0, 255));
      tq.push_back(d);
    end
    foreach (tq[i]) send_byte(tq[i], 1'b0, '0);
    rand_cnt += tq.size();
  endtask

  // stimulus
  initial begin : stimulus
    row_t dir_tab [$];
    logic [7:0] tv, av;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_TOGGLE;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    tab_typed     = 1'b0;
    tab_res       = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: byte extremes in raw mode, toggle, quote, keys,
    // saturated position report, attention, toggle inside a sequence
    dir_tab.push_back(mk_row(ROW_BYTE, 8'h00, CFG_TOGGLE, 1'b1,
      result_t'({KIND_RAW, K_ASCII, 8'h00, 16'd0, 16'd0, 1'b0})));
    dir_tab.push_back(mk_row(ROW_BYTE, 8'hFF, CFG_TOGGLE, 1'b1,
      result_t'({KIND_RAW, K_ASCII, 8'hFF, 16'd0, 16'd0, 1'b0})));
    dir_tab.push_back(mk_row(ROW_BYTE, TOGGLE_RST, CFG_TOGGLE, 1'b1,
      result_t'({KIND_MODE, K_ASCII, 8'h00, 16'd0, 16'd0, 1'b1})));
    dir_tab.push_back(byte_row(CH_CTRL_V));
    dir_tab.push_back(byte_row(TOGGLE_RST));
    dir_tab.push_back(byte_row(CH_CTRL_A));
    dir_tab.push_back(byte_row(CH_ESC));
    dir_tab.push_back(byte_row(CH_LBRACK));
    dir_tab.push_back(byte_row(CH_UP_D));
    dir_tab.push_back(byte_row(CH_ESC));
    dir_tab.push_back(byte_row(CH_LBRACK));
    repeat (5) dir_tab.push_back(byte_row(CH_NINE));
    dir_tab.push_back(byte_row(CH_SEMI));
    dir_tab.push_back(byte_row(CH_ZERO));
    dir_tab.push_back(mk_row(ROW_BYTE, CH_UP_R, CFG_TOGGLE, 1'b1,
      result_t'({KIND_KEY, K_POS, 8'h00, 16'hFFFF, 16'd0, 1'b1})));
    dir_tab.push_back(mk_row(ROW_CFG, 8'hFF, CFG_TOGGLE, 1'b0, '0));
    dir_tab.push_back(mk_row(ROW_CFG, CH_CTRL_C, CFG_ATTN, 1'b0, '0));
    dir_tab.push_back(mk_row(ROW_BYTE, CH_CTRL_C, CFG_TOGGLE, 1'b1,
      result_t'({KIND_ATTN, K_ASCII, 8'h00, 16'd0, 16'd0, 1'b1})));
    dir_tab.push_back(byte_row(CH_CTRL_E));
    dir_tab.push_back(byte_row(CH_ESC));
    dir_tab.push_back(byte_row(CH_LBRACK));
    dir_tab.push_back(mk_row(ROW_BYTE, 8'hFF, CFG_TOGGLE, 1'b1,
      result_t'({KIND_MODE, K_ASCII, 8'h00, 16'd0, 16'd0, 1'b0})));
    dir_tab.push_back(mk_row(ROW_BYTE, 8'h71, CFG_TOGGLE, 1'b1,
      result_t'({KIND_RAW, K_ASCII, 8'h71, 16'd0, 16'd0, 1'b0})));
    dir_tab.push_back(mk_row(ROW_BYTE, 8'hFF, CFG_TOGGLE, 1'b1,
      result_t'({KIND_MODE, K_ASCII, 8'h00, 16'd0, 16'd0, 1'b1})));
    dir_tab.push_back(byte_row(CH_UP_C));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG) begin
        wait_drained();
        write_cfg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_byte(dir_tab[i].val, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      tv = 8'($urandom_range(0, 255));
      av = 8'($urandom_range(0, 255));
      case (ph)
        0: begin tv = TOGGLE_RST; av = ATTN_RST; end
        1: begin tv = 8'hFF; av = 8'h00; end
        2: begin tv = 8'h00; av = 8'hFF; end
        4: av = tv;
        5: begin tv = CH_ZERO + 8'd1; av = CH_SEMI; end
        6: begin tv = CH_ESC; av = CH_UP_R; end
        default: ;
      endcase
      write_cfg(CFG_TOGGLE, tv);
      write_cfg(CFG_ATTN, av);
      gen_cmd = cmd_on;
      steady = (ph == 3) || (ph == 6);
      if (ph == 2) -> hold_ev;
      while (rand_cnt < (ph + 1) * RAND_ITEMS / N_PHASES) send_token();
    end
    wait_drained();

    $display("sent %0d bytes over %0d register writes, checked %0d words", byte_cnt, cfg_cnt,
             word_cnt);
    $display("words: %0d keys, %0d position reports, %0d raw, %0d mode, %0d attention",
             key_cnt, pos_cnt, raw_cnt, mode_cnt, attn_cnt);
    if (err_cnt == 0 && expected_words.size() == 0) begin
      $display("[console_key_escape_decoder] OK");
    end else begin
      $display("[console_key_escape_decoder] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/ckd_pkg.sv
design/ckd_if.sv
design/ckd_decode.sv
design/console_key_escape_decoder.sv
sim/console_key_escape_decoder_tb.sv
